### design/mad_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Moving average deviation package
// Shared types, status codes and fixed constants of the deviation block.
// ----------------------------------------------------------------------------
package mad_pkg;

    localparam int DATA_W  = 32;
    localparam int CFG_W   = 5;
    localparam int APB_AW  = 3;
    localparam int GAP_MAX = 63;

    localparam logic [CFG_W-1:0] WINDOW_RESET = 5'd6;

    // register index taken from paddr[2]
    localparam logic [0:0] REG_WINDOW = 1'b0;

    // result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_ORDER = 2'd1;
    localparam logic [1:0] ST_GAP   = 2'd2;

    // last step of the 32-step divider
    localparam logic [4:0] BIT_LAST = 5'(DATA_W - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DAY,
        S_SUM,
        S_DIV,
        S_EMIT,
        S_PUSH,
        S_ERR
    } t_state;

endpackage
`default_nettype wire

### design/mad_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module mad_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_wr_en,
    input  wire logic [AW-1:0]    i_wr_addr,
    input  wire logic [WIDTH-1:0] i_wr_data,
    input  wire logic             i_rd_en,
    input  wire logic [AW-1:0]    i_rd_addr,
    output logic      [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule
`default_nettype wire

### design/moving_average_deviation_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Moving average deviation - top level
// Trailing moving-average absolute deviation over keyed, day-ordered samples.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel (i_valid / o_stall) carries key, day, sample and region
//    flag. A request is taken when i_valid is high and o_stall low.
//  - Output channel (o_valid / i_stall) carries none, one or several results
//    per input request; o_last marks the final one.
//  - APB port holds window_len at address 0 (reset value 6). Write it only
//    while the block is idle.
//  - A series start gives no result. A rejected day (not increasing, or gap
//    above 63) gives one error result.
//  - A day handled while the history is shorter than the window goes
//    straight into the history. Else the block sums the last w entries
//    (w = effective window) of the history RAM through its single read
//    port, then the shared restoring divider makes the 32 quotient bits,
//    one quotient bit per cycle.
//  - o_stall is high while a request is being worked on. A result waiting
//    in the output register does not block a new request; only the next
//    result load waits while the receiver stalls.
//  - i_rst_n is synchronous: it clears the series, the window length to 6
//    and the output valid. The history RAM needs no clearing, as only
//    entries written within the current series are ever read.
// ----------------------------------------------------------------------------
module moving_average_deviation_top
    import mad_pkg::*;
#(
    parameter int WINDOW_MAX = 16
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    // input channel
    input  wire logic              i_valid,
    output logic                   o_stall,
    input  wire logic [DATA_W-1:0] i_key_id,
    input  wire logic [DATA_W-1:0] i_day,
    input  wire logic [DATA_W-1:0] i_sample,
    input  wire logic              i_has_region,
    // output channel
    output logic                   o_valid,
    input  wire logic              i_stall,
    output logic      [DATA_W-1:0] o_out_key,
    output logic      [DATA_W-1:0] o_out_day,
    output logic      [DATA_W-1:0] o_deviation,
    output logic      [1:0]        o_status,
    output logic                   o_last,
    // configuration port
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [APB_AW-1:0] paddr,
    input  wire logic [31:0]       pwdata,
    output logic      [31:0]       prdata,
    output logic                   pready
);

    // history pointer, window count and sum widths
    localparam int LOG_W = $clog2(WINDOW_MAX);
    localparam int WIN_W = $clog2(WINDOW_MAX + 1);
    localparam int SUM_W = DATA_W + LOG_W;
    localparam logic [LOG_W-1:0] PTR_LAST = LOG_W'(WINDOW_MAX - 1);
    localparam logic [WIN_W-1:0] WIN_FULL = WIN_W'(WINDOW_MAX);

    // ---- control state ----
    t_state             r_state, n_state;
    logic [CFG_W-1:0]   r_window_len;
    logic               r_active, n_active;
    logic               r_region, n_region;
    logic [WIN_W-1:0]   r_days, n_days;
    logic [LOG_W-1:0]   r_head, n_head;
    logic [WIN_W-1:0]   r_rd_idx, n_rd_idx;
    logic [LOG_W-1:0]   r_rd_ptr, n_rd_ptr;
    logic               r_pend, n_pend;
    logic [4:0]         r_bit, n_bit;
    logic               r_out_valid, n_out_valid;

    // ---- payload state ----
    logic [DATA_W-1:0]  r_cur_key, n_cur_key;
    logic [DATA_W-1:0]  r_last_day, n_last_day;
    logic [DATA_W-1:0]  r_cur_day, n_cur_day;
    logic [DATA_W-1:0]  r_sample, n_sample;
    logic [1:0]         r_err, n_err;
    logic [SUM_W-1:0]   r_acc, n_acc;
    logic [WIN_W-1:0]   r_rem, n_rem;
    logic [DATA_W-1:0]  r_out_key, n_out_key;
    logic [DATA_W-1:0]  r_out_day, n_out_day;
    logic [DATA_W-1:0]  r_dev, n_dev;
    logic [1:0]         r_status, n_status;
    logic               r_last, n_last;

    // ---- RAM port ----
    logic               ram_wr_en;
    logic [LOG_W-1:0]   ram_wr_addr;
    logic [DATA_W-1:0]  ram_wr_data;
    logic               ram_rd_en;
    logic [LOG_W-1:0]   ram_rd_addr;
    logic [DATA_W-1:0]  ram_rd_data;

    // ---- datapath nets ----
    logic [WIN_W-1:0]   w_eff;
    logic               in_acc;
    logic               out_free;
    logic               new_series;
    logic [DATA_W-1:0]  gap;
    logic               own_day;
    logic [DATA_W-1:0]  day_val;
    logic [DATA_W-1:0]  avg;
    logic [WIN_W:0]     rem_sh;
    logic               q_bit;
    logic               cfg_wr;

    // ------------------------------------------------------------------
    // Configuration: window_len only; other addresses read as zero.
    // ------------------------------------------------------------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_WINDOW);

    always_comb begin
        prdata = '0;
        if (paddr[2] == REG_WINDOW) begin
            prdata = 32'(r_window_len);
        end
    end

    // Effective window: zero means one, clipped to the history depth
    always_comb begin
        if (r_window_len == '0) begin
            w_eff = WIN_W'(1);
        end else if (32'(r_window_len) > 32'(WINDOW_MAX)) begin
            w_eff = WIN_FULL;
        end else begin
            w_eff = WIN_W'(r_window_len);
        end
    end

    // ------------------------------------------------------------------
    // Handshake and common terms
    // ------------------------------------------------------------------
    assign o_stall    = (r_state != S_IDLE);
    assign in_acc     = i_valid && !o_stall;
    assign out_free   = !r_out_valid || !i_stall;
    assign new_series = !r_active || (i_key_id != r_cur_key);
    assign gap        = i_day - r_last_day;

    // Gap days count as zero samples
    assign own_day = (r_cur_day == r_last_day);
    assign day_val = own_day ? r_sample : '0;
    assign avg     = r_acc[DATA_W-1:0];

    // Shared divider step: remainder shifted left with the next dividend bit
    assign rem_sh = {r_rem, r_acc[DATA_W-1]};
    assign q_bit  = (rem_sh >= {1'b0, w_eff});

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb begin
        n_state     = r_state;
        n_active    = r_active;
        n_region    = r_region;
        n_days      = r_days;
        n_head      = r_head;
        n_rd_idx    = r_rd_idx;
        n_rd_ptr    = r_rd_ptr;
        n_pend      = 1'b0;
        n_bit       = r_bit;
        n_out_valid = r_out_valid && i_stall;
        n_cur_key   = r_cur_key;
        n_last_day  = r_last_day;
        n_cur_day   = r_cur_day;
        n_sample    = r_sample;
        n_err       = r_err;
        n_acc       = r_acc;
        n_rem       = r_rem;
        n_out_key   = r_out_key;
        n_out_day   = r_out_day;
        n_dev       = r_dev;
        n_status    = r_status;
        n_last      = r_last;
        ram_wr_en   = 1'b0;
        ram_wr_addr = r_head;
        ram_wr_data = day_val;
        ram_rd_en   = 1'b0;
        ram_rd_addr = r_rd_ptr;

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (new_series) begin
                        // fresh series: first sample goes to slot 0
                        n_active    = 1'b1;
                        n_cur_key   = i_key_id;
                        n_region    = i_has_region;
                        n_last_day  = i_day;
                        n_days      = WIN_W'(1);
                        n_head      = LOG_W'(1);
                        ram_wr_en   = 1'b1;
                        ram_wr_addr = '0;
                        ram_wr_data = i_sample;
                    end else if (i_day <= r_last_day) begin
                        n_err     = ST_ORDER;
                        n_cur_day = i_day;
                        n_state   = S_ERR;
                    end else if (gap > 32'(GAP_MAX)) begin
                        n_err     = ST_GAP;
                        n_cur_day = i_day;
                        n_state   = S_ERR;
                    end else begin
                        n_cur_day  = r_last_day + 32'd1;
                        n_last_day = i_day;
                        n_sample   = i_sample;
                        n_state    = S_DAY;
                    end
                end
            end

            S_DAY: begin
                if (r_days >= w_eff) begin
                    n_acc    = '0;
                    n_rd_idx = '0;
                    n_rd_ptr = (r_head == '0) ? PTR_LAST : r_head - LOG_W'(1);
                    n_state  = S_SUM;
                end else begin
                    n_state = S_PUSH;
                end
            end

            S_SUM: begin
                // walk back through the ring, one read a cycle
                if (r_rd_idx != w_eff) begin
                    ram_rd_en = 1'b1;
                    n_pend    = 1'b1;
                    n_rd_idx  = r_rd_idx + WIN_W'(1);
                    n_rd_ptr  = (r_rd_ptr == '0) ? PTR_LAST : r_rd_ptr - LOG_W'(1);
                end
                if (r_pend) begin
                    n_acc = r_acc + SUM_W'(ram_rd_data);
                end
                if (r_pend && (r_rd_idx == w_eff)) begin
                    // sum < w * 2^32, so the upper bits already form the
                    // partial remainder and only 32 quotient bits remain
                    n_rem   = WIN_W'(n_acc[SUM_W-1:DATA_W]);
                    n_bit   = '0;
                    n_state = S_DIV;
                end
            end

            S_DIV: begin
                n_rem = q_bit ? WIN_W'(rem_sh - {1'b0, w_eff}) : rem_sh[WIN_W-1:0];
                n_acc = {r_acc[SUM_W-1:DATA_W], r_acc[DATA_W-2:0], q_bit};
                n_bit = r_bit + 5'd1;
                if (r_bit == BIT_LAST) begin
                    n_state = S_EMIT;
                end
            end

            S_EMIT: begin
                if (!r_region) begin
                    n_state = S_PUSH;
                end else if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_key   = r_cur_key;
                    n_out_day   = r_cur_day;
                    n_dev       = (avg >= day_val) ? avg - day_val : day_val - avg;
                    n_status    = ST_OK;
                    // once a day has a full window, every later day has too
                    n_last      = own_day;
                    n_state     = S_PUSH;
                end
            end

            S_PUSH: begin
                ram_wr_en = 1'b1;
                n_head    = (r_head == PTR_LAST) ? '0 : r_head + LOG_W'(1);
                if (r_days != WIN_FULL) begin
                    n_days = r_days + WIN_W'(1);
                end
                if (own_day) begin
                    n_state = S_IDLE;
                end else begin
                    n_cur_day = r_cur_day + 32'd1;
                    n_state   = S_DAY;
                end
            end

            S_ERR: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_key   = r_cur_key;
                    n_out_day   = r_cur_day;
                    n_dev       = '0;
                    n_status    = r_err;
                    n_last      = 1'b1;
                    n_state     = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_window_len <= WINDOW_RESET;
            r_active     <= 1'b0;
            r_region     <= 1'b0;
            r_days       <= '0;
            r_head       <= '0;
            r_rd_idx     <= '0;
            r_rd_ptr     <= '0;
            r_pend       <= 1'b0;
            r_bit        <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state     <= n_state;
            if (cfg_wr) begin
                r_window_len <= pwdata[CFG_W-1:0];
            end
            r_active    <= n_active;
            r_region    <= n_region;
            r_days      <= n_days;
            r_head      <= n_head;
            r_rd_idx    <= n_rd_idx;
            r_rd_ptr    <= n_rd_ptr;
            r_pend      <= n_pend;
            r_bit       <= n_bit;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur_key  <= n_cur_key;
        r_last_day <= n_last_day;
        r_cur_day  <= n_cur_day;
        r_sample   <= n_sample;
        r_err      <= n_err;
        r_acc      <= n_acc;
        r_rem      <= n_rem;
        r_out_key  <= n_out_key;
        r_out_day  <= n_out_day;
        r_dev      <= n_dev;
        r_status   <= n_status;
        r_last     <= n_last;
    end

    // ------------------------------------------------------------------
    // History ring
    // ------------------------------------------------------------------
    mad_ram #(
        .WIDTH (DATA_W),
        .DEPTH (WINDOW_MAX),
        .AW    (LOG_W)
    ) u_hist (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (ram_wr_data),
        .i_rd_en   (ram_rd_en),
        .i_rd_addr (ram_rd_addr),
        .o_rd_data (ram_rd_data)
    );

    // ------------------------------------------------------------------
    // Outputs
    // ------------------------------------------------------------------
    assign o_valid     = r_out_valid;
    assign o_out_key   = r_out_key;
    assign o_out_day   = r_out_day;
    assign o_deviation = r_dev;
    assign o_status    = r_status;
    assign o_last      = r_last;

endmodule
`default_nettype wire

### design/mad_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Moving average deviation checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module mad_checker
    import mad_pkg::*;
(
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              o_valid,
    input wire logic              i_stall,
    input wire logic [DATA_W-1:0] o_out_key,
    input wire logic [DATA_W-1:0] o_out_day,
    input wire logic [DATA_W-1:0] o_deviation,
    input wire logic [1:0]        o_status,
    input wire logic              o_last
);

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_out_key) && $stable(o_out_day)
            && $stable(o_deviation) && $stable(o_status) && $stable(o_last))
        else $error("stalled result changed");

    // an error result is the only result of its request
    a_err_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status != ST_OK) |-> o_last)
        else $error("error result without last");

    // error results carry no deviation
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status != ST_OK) |-> (o_deviation == '0))
        else $error("error result with deviation");

    // reset empties the output register
    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

endmodule

bind moving_average_deviation_top mad_checker u_mad_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_valid     (o_valid),
    .i_stall     (i_stall),
    .o_out_key   (o_out_key),
    .o_out_day   (o_out_day),
    .o_deviation (o_deviation),
    .o_status    (o_status),
    .o_last      (o_last)
);
`default_nettype wire

### dv/mad_deviation_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Moving average deviation checker
// Watches the request, result and APB ports, works out every expected result
// from its own copy of the series state and compares results in order.
// ----------------------------------------------------------------------------
module mad_deviation_checker
    import mad_pkg::*;
#(
    parameter int WINDOW_MAX = 16
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    input  wire logic              o_stall,
    input  wire logic [DATA_W-1:0] i_key_id,
    input  wire logic [DATA_W-1:0] i_day,
    input  wire logic [DATA_W-1:0] i_sample,
    input  wire logic              i_has_region,
    input  wire logic              o_valid,
    input  wire logic              i_stall,
    input  wire logic [DATA_W-1:0] o_out_key,
    input  wire logic [DATA_W-1:0] o_out_day,
    input  wire logic [DATA_W-1:0] o_deviation,
    input  wire logic [1:0]        o_status,
    input  wire logic              o_last,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [APB_AW-1:0] paddr,
    input  wire logic [31:0]       pwdata,
    input  wire logic              pready,
    output int                     fail_count,
    output int                     open_count
);

    typedef struct packed {
        logic [DATA_W-1:0] key;
        logic [DATA_W-1:0] day;
        logic [DATA_W-1:0] dev;
        logic [1:0]        status;
        logic              last;
    } t_dev_result;

    t_dev_result       due_results[$];
    int                errors     = 0;
    int                open_r     = 0;

    logic [CFG_W-1:0]  window_len = WINDOW_RESET;
    logic [DATA_W-1:0] cur_key    = '0;
    logic [DATA_W-1:0] last_day   = '0;
    logic              series_on  = 1'b0;
    logic              region_on  = 1'b0;
    int unsigned       days_seen  = 0;
    int unsigned       head       = 0;
    logic [DATA_W-1:0] hist [WINDOW_MAX];

    assign fail_count = errors;
    assign open_count = open_r;

    function automatic int unsigned window_eff();
        if (window_len == '0) return 1;
        if (window_len > WINDOW_MAX) return WINDOW_MAX;
        return window_len;
    endfunction

    task automatic clear_series();
        int unsigned i;
        for (i = 0; i < WINDOW_MAX; i++) hist[i] = '0;
        head      = 0;
        days_seen = 0;
    endtask

    task automatic store_sample(input logic [DATA_W-1:0] v);
        hist[head] = v;
        head = (head + 1) % WINDOW_MAX;
        if (days_seen < WINDOW_MAX) days_seen++;
    endtask

    // append one predicted result at the tail
    task automatic queue_result(input t_dev_result r);
        due_results.insert(due_results.size(), r);
    endtask

    // one day of the series: deviation from the trailing mean, then into history
    task automatic add_day(input logic [DATA_W-1:0] d, input logic [DATA_W-1:0] v);
        int unsigned w;
        int unsigned i;
        logic [63:0] sum;
        logic [63:0] mean;
        logic [DATA_W-1:0] dev;
        w = window_eff();
        if (days_seen >= w) begin
            sum = '0;
            for (i = 1; i <= w; i++) sum += 64'(hist[(head + WINDOW_MAX - i) % WINDOW_MAX]);
            if (region_on) begin
                mean = sum / w;
                dev  = (mean >= 64'(v)) ? DATA_W'(mean - 64'(v)) : DATA_W'(64'(v) - mean);
                queue_result(t_dev_result'{cur_key, d, dev, ST_OK, 1'b0});
            end
        end
        store_sample(v);
    endtask

    task automatic track_request(input logic [DATA_W-1:0] key, input logic [DATA_W-1:0] day,
                                 input logic [DATA_W-1:0] smp, input logic mapped);
        int unsigned first;
        logic [DATA_W-1:0] gap;
        logic [DATA_W-1:0] t;
        t_dev_result r;
        if (!series_on || key != cur_key) begin
            series_on = 1'b1;
            cur_key   = key;
            region_on = mapped;
            last_day  = day;
            clear_series();
            store_sample(smp);
        end else if (day <= last_day || day - last_day > GAP_MAX) begin
            queue_result(t_dev_result'{key, day, '0,
                         (day <= last_day) ? ST_ORDER : ST_GAP, 1'b1});
        end else begin
            first = due_results.size();
            gap   = day - last_day;
            for (t = 1; t < gap; t++) add_day(last_day + t, '0);
            add_day(day, smp);
            last_day = day;
            if (due_results.size() > first) begin
                r = due_results[$];
                r.last = 1'b1;
                due_results[$] = r;
            end
        end
    endtask

    task automatic check_field(input string what, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %h, got %h", $time, what, want, got);
            errors++;
        end
    endtask

    task automatic compare_result();
        t_dev_result want;
        if (due_results.size() == 0) begin
            $display("%0t: unexpected result, expected none, got key %h day %h dev %h st %0d",
                     $time, o_out_key, o_out_day, o_deviation, o_status);
            errors++;
        end else begin
            want = due_results.pop_front();
            check_field("out_key",   want.key,    o_out_key);
            check_field("out_day",   want.day,    o_out_day);
            check_field("deviation", want.dev,    o_deviation);
            check_field("status",    32'(want.status), 32'(o_status));
            check_field("last",      32'(want.last),   32'(o_last));
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            due_results.delete();
            window_len = WINDOW_RESET;
            cur_key    = '0;
            last_day   = '0;
            series_on  = 1'b0;
            region_on  = 1'b0;
            clear_series();
        end else begin
            if (o_valid && !i_stall) compare_result();
            if (psel && penable && pwrite && pready && paddr[APB_AW-1:2] == REG_WINDOW)
                window_len = pwdata[CFG_W-1:0];
            if (i_valid && !o_stall) track_request(i_key_id, i_day, i_sample, i_has_region);
        end
        open_r <= due_results.size();
    end

endmodule

### dv/moving_average_deviation_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Moving average deviation testbench
// Directed series hitting the day and sample extremes and both error kinds,
// then random keyed series under four idling phases, each with its own
// window length. The checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module moving_average_deviation_top_tb;
    import mad_pkg::*;

    localparam int WINDOW_MAX       = 16;
    localparam int RANDOM_PER_PHASE = 20;
    // worst request: a full gap of days, each summed over the window and divided
    localparam int DRAIN_CYCLES     = (GAP_MAX + 1) * (WINDOW_MAX + 36) + 16;

    localparam logic [APB_AW-1:0] ADDR_WINDOW = {REG_WINDOW, 2'b00};
    localparam logic [APB_AW-1:0] ADDR_SPARE  = {~REG_WINDOW, 2'b00};

    logic              i_clk;
    logic              i_rst_n      = 1'b0;
    logic              i_valid      = 1'b0;
    logic              o_stall;
    logic [DATA_W-1:0] i_key_id     = '0;
    logic [DATA_W-1:0] i_day        = '0;
    logic [DATA_W-1:0] i_sample     = '0;
    logic              i_has_region = 1'b0;
    logic              o_valid;
    logic              i_stall      = 1'b0;
    logic [DATA_W-1:0] o_out_key;
    logic [DATA_W-1:0] o_out_day;
    logic [DATA_W-1:0] o_deviation;
    logic [1:0]        o_status;
    logic              o_last;
    logic              psel         = 1'b0;
    logic              penable      = 1'b0;
    logic              pwrite       = 1'b0;
    logic [APB_AW-1:0] paddr        = '0;
    logic [31:0]       pwdata       = '0;
    logic [31:0]       prdata;
    logic              pready;

    int fail_count;
    int open_count;

    // idling odds in percent, per cycle
    int send_idle_pct = 0;
    int stall_pct     = 0;

    moving_average_deviation_top #(.WINDOW_MAX(WINDOW_MAX)) i_dut (.*);

    mad_deviation_checker #(.WINDOW_MAX(WINDOW_MAX)) u_checker (.*);

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // receiver side: stall drawn fresh every cycle
    always @(posedge i_clk) begin
        i_stall <= ($urandom_range(99) < stall_pct);
    end

    // generous ceiling, well above the slowest legal run
    initial begin
        #60_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Sender: optional idle cycles with valid low, then hold the request
    // until it is taken. Valid stays high on return so back-to-back requests
    // need only one assignment per edge.
    task automatic send_request(input logic [DATA_W-1:0] key, input logic [DATA_W-1:0] day,
                                input logic [DATA_W-1:0] smp, input logic mapped);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_key_id     <= key;
        i_day        <= day;
        i_sample     <= smp;
        i_has_region <= mapped;
        do @(posedge i_clk); while (o_stall);
    endtask

    // Drop valid, wait for every predicted result, then give the block time
    // to finish a request that produces nothing (no region mapping).
    task automatic settle();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (open_count != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // APB write: setup, access, then psel dropped so calls can follow
    task automatic write_reg(input logic [APB_AW-1:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    // One keyed series: mostly well-formed increasing days with small gaps,
    // some long gaps, and a few repeats, backward days and oversize gaps.
    // good_day follows the last day the block keeps, so an error request
    // leaves the rest of the series intact.
    task automatic random_series(input int unsigned n_items);
        logic [DATA_W-1:0] key;
        logic [DATA_W-1:0] day;
        logic [DATA_W-1:0] good_day;
        logic [DATA_W-1:0] smp;
        logic              mapped;
        int unsigned       roll;
        int unsigned       i;
        key    = $urandom;
        mapped = ($urandom_range(99) < 80);
        roll   = $urandom_range(99);
        if (roll < 10)      good_day = '0;
        else if (roll < 20) good_day = 32'hFFFF_FFFF - $urandom_range(80);
        else                good_day = $urandom_range(32'hFFFF_0000);
        for (i = 0; i < n_items; i++) begin
            if (i == 0) begin
                day = good_day;
            end else begin
                roll = $urandom_range(99);
                if (roll < 92) begin
                    day = good_day + ((roll < 65) ? 1 :
                                      (roll < 85) ? $urandom_range(6, 2) :
                                                    $urandom_range(GAP_MAX, 7));
                    // wrapping past the top gives an order error, kept day unchanged
                    if (day > good_day) good_day = day;
                end else if (roll < 96) begin
                    day = good_day - $urandom_range(3);
                end else begin
                    day = good_day + $urandom_range(300, GAP_MAX + 1);
                end
            end
            roll = $urandom_range(99);
            smp  = (roll < 10) ? '0 : (roll < 20) ? '1 :
                   (roll < 50) ? DATA_W'($urandom_range(1000)) : DATA_W'($urandom);
            // region flag is only taken at series start; later values are noise
            send_request(key, day, smp, (i == 0) ? mapped : 1'($urandom));
        end
    endtask

    initial begin
        int unsigned phase;
        int unsigned sent;
        int unsigned len;
        logic [CFG_W-1:0] win;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // --- directed, window at its reset value of 6, no idling ---
        // all-ones series: window sum near its top bit, mean all ones
        send_request(32'h0000_0000, 32'd0, 32'hFFFF_FFFF, 1'b1);
        send_request(32'h0000_0000, 32'd1, 32'hFFFF_FFFF, 1'b1);
        send_request(32'h0000_0000, 32'd2, 32'hFFFF_FFFF, 1'b1);
        send_request(32'h0000_0000, 32'd3, 32'hFFFF_FFFF, 1'b1);
        send_request(32'h0000_0000, 32'd4, 32'hFFFF_FFFF, 1'b1);
        send_request(32'h0000_0000, 32'd5, 32'hFFFF_FFFF, 1'b1);
        // sample zero against an all-ones mean
        send_request(32'h0000_0000, 32'd6, 32'h0000_0000, 1'b1);
        // repeated day, then a backward day
        send_request(32'h0000_0000, 32'd6, 32'h0000_0001, 1'b1);
        send_request(32'h0000_0000, 32'd2, 32'h0000_0001, 1'b1);
        // gap one past the limit, then exactly at it (zero-filled gap days)
        send_request(32'h0000_0000, 32'd70, 32'h0000_0001, 1'b1);
        send_request(32'h0000_0000, 32'd69, 32'h1234_5678, 1'b0);
        send_request(32'h0000_0000, 32'd71, 32'h0000_0007, 1'b1);
        // unmapped key near the top of the day range: state moves, no ok results
        send_request(32'hFFFF_FFFF, 32'hFFFF_FFC0, 32'h0000_0005, 1'b0);
        send_request(32'hFFFF_FFFF, 32'hFFFF_FFC8, 32'h0000_0003, 1'b1);
        send_request(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0009, 1'b1);
        // errors are still reported without a region mapping
        send_request(32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0009, 1'b1);
        send_request(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0009, 1'b0);
        // back to key zero: a change of key always restarts
        send_request(32'h0000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1);
        send_request(32'h0000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1);

        // --- random phases; window written only once the block is quiet ---
        for (phase = 0; phase < 4; phase++) begin
            settle();
            case (phase)
                0: begin
                    // zero acts as one
                    win = 5'd0;
                    send_idle_pct = 0;
                    stall_pct    <= 0;
                end
                1: begin
                    win = 5'd16;
                    send_idle_pct = 83;
                    stall_pct    <= 0;
                end
                2: begin
                    // above the maximum, saturates
                    win = 5'd31;
                    send_idle_pct = 0;
                    stall_pct    <= 83;
                end
                default: begin
                    win = CFG_W'($urandom_range(15, 1));
                    send_idle_pct = 24;
                    stall_pct    <= 24;
                    // unmapped register: must be ignored
                    write_reg(ADDR_SPARE, $urandom);
                end
            endcase
            // upper data bits are don't-care
            write_reg(ADDR_WINDOW, {27'($urandom), win});
            sent = 0;
            while (sent < RANDOM_PER_PHASE) begin
                len = $urandom_range(30, 1);
                if (len > RANDOM_PER_PHASE - sent) len = RANDOM_PER_PHASE - sent;
                random_series(len);
                sent += len;
            end
        end

        settle();
        if (fail_count == 0 && open_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
